### hw/rtl/free_list_page_allocator_assert.svh
// assertion macros used by the checker file
`ifndef FREE_LIST_PAGE_ALLOCATOR_ASSERT_SVH
`define FREE_LIST_PAGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define FLPA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define FLPA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

### hw/rtl/flpa_pkg.sv
`default_nettype none

package flpa_pkg;

    // payload widths
    localparam int REQ_W      = 2;
    localparam int FRAME_W    = 16;
    localparam int PAGES_W    = 17;
    localparam int STATUS_W   = 2;
    // base + pages never needs more than this
    localparam int SUM_MIN_W  = PAGES_W + 1;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic walk;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic walk_needed;
        logic walk_last;
    } t_dp_sts;

endpackage

`default_nettype wire

### hw/rtl/flpa_ram.sv
`default_nettype none

module flpa_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/flpa_ctrl.sv
`default_nettype none

module flpa_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire flpa_pkg::t_dp_sts  i_sts,
    output flpa_pkg::t_dp_cmd       o_cmd,
    output logic                    o_busy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = i_sts.walk_needed ? S_WALK : S_IDLE;
            end
            S_WALK: begin
                if (i_sts.walk_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands to the datapath
    assign o_busy      = (r_state != S_IDLE);
    assign o_cmd.latch = (r_state == S_IDLE) && i_start;
    assign o_cmd.exec  = (r_state == S_EXEC);
    assign o_cmd.walk  = (r_state == S_WALK);

endmodule

`default_nettype wire

### hw/rtl/flpa_dp.sv
`default_nettype none

module flpa_dp #(
    parameter int NUM_PAGES = 65536
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire flpa_pkg::t_dp_cmd                i_cmd,
    output flpa_pkg::t_dp_sts                     o_sts,
    input  wire logic [flpa_pkg::REQ_W-1:0]       i_req_type,
    input  wire logic [flpa_pkg::FRAME_W-1:0]     i_region_base_frame,
    input  wire logic [flpa_pkg::PAGES_W-1:0]     i_region_pages,
    input  wire logic                             i_region_usable,
    input  wire logic [flpa_pkg::FRAME_W-1:0]     i_free_frame,
    output logic                                  o_done,
    output logic      [flpa_pkg::STATUS_W-1:0]    o_status,
    output logic      [flpa_pkg::FRAME_W-1:0]     o_alloc_frame
);

    localparam int FW    = flpa_pkg::FRAME_W;
    localparam int PW    = flpa_pkg::PAGES_W;
    localparam int AW    = $clog2(NUM_PAGES);
    localparam int LW    = AW + 1;
    localparam int NPW   = $clog2(NUM_PAGES + 1);
    localparam int SUM_W = (NPW > flpa_pkg::SUM_MIN_W) ? NPW : flpa_pkg::SUM_MIN_W;

    // latched request
    logic [flpa_pkg::REQ_W-1:0] r_kind;
    logic [FW-1:0]              r_base;
    logic [PW-1:0]              r_pages;
    logic                       r_usable;
    logic [FW-1:0]              r_free;

    // list pointers and page walker
    logic [AW-1:0] r_head, n_head;
    logic          r_head_valid, n_head_valid;
    logic [AW-1:0] r_tail, n_tail;
    logic          r_tail_valid, n_tail_valid;
    logic [AW-1:0] r_cur, n_cur;
    logic [PW-1:0] r_left, n_left;

    // result registers
    logic                          r_done, n_done;
    logic [flpa_pkg::STATUS_W-1:0] r_status, n_status;
    logic [FW-1:0]                 r_alloc, n_alloc;

    // link memory port
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [LW-1:0] w_wdata;
    logic [LW-1:0] w_rdata;

    logic [SUM_W-1:0] w_sum;
    logic             w_oor;
    logic             w_free_ok;
    logic             w_load_go;
    logic             w_last;

    // request decode
    assign w_sum     = SUM_W'(r_base) + SUM_W'(r_pages);
    assign w_oor     = w_sum > SUM_W'(NUM_PAGES);
    assign w_free_ok = SUM_W'(r_free) < SUM_W'(NUM_PAGES);
    assign w_load_go = (r_kind == flpa_pkg::REQ_LOAD) && r_usable && !w_oor
                       && (r_pages != '0);
    assign w_last    = (r_left == PW'(1));

    assign o_sts.walk_needed = w_load_go;
    assign o_sts.walk_last   = w_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind   <= i_req_type;
            r_base   <= i_region_base_frame;
            r_pages  <= i_region_pages;
            r_usable <= i_region_usable;
            r_free   <= i_free_frame;
        end
    end

    // link memory, entry = {next frame, end of list}
    flpa_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_PAGES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    // link writes: free pushes, load links old tail, walk chains pages
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cur;
        w_wdata = {r_cur + AW'(1), 1'b0};
        if (i_cmd.exec) begin
            if ((r_kind == flpa_pkg::REQ_FREE) && w_free_ok) begin
                w_we    = 1'b1;
                w_waddr = AW'(r_free);
                w_wdata = {r_head, !r_head_valid};
            end else if (w_load_go && r_tail_valid) begin
                w_we    = 1'b1;
                w_waddr = r_tail;
                w_wdata = {AW'(r_base), 1'b0};
            end
        end
        if (i_cmd.walk) begin
            w_we    = 1'b1;
            w_waddr = r_cur;
            w_wdata = w_last ? {AW'(0), 1'b1} : {r_cur + AW'(1), 1'b0};
        end
    end

    // pointer and result updates
    always_comb begin
        n_head       = r_head;
        n_head_valid = r_head_valid;
        n_tail       = r_tail;
        n_tail_valid = r_tail_valid;
        n_cur        = r_cur;
        n_left       = r_left;
        n_done       = 1'b0;
        n_status     = r_status;
        n_alloc      = r_alloc;
        if (i_cmd.exec) begin
            n_done   = !w_load_go;
            n_status = flpa_pkg::ST_OK;
            n_alloc  = '0;
            case (r_kind)
                flpa_pkg::REQ_LOAD: begin
                    if (r_usable && w_oor) begin
                        n_status = flpa_pkg::ST_RANGE;
                    end
                    if (w_load_go) begin
                        if (!r_head_valid) begin
                            n_head       = AW'(r_base);
                            n_head_valid = 1'b1;
                        end
                        n_cur  = AW'(r_base);
                        n_left = r_pages;
                    end
                end
                flpa_pkg::REQ_ALLOC: begin
                    if (!r_head_valid) begin
                        n_status = flpa_pkg::ST_OOM;
                    end else begin
                        n_alloc = FW'(r_head);
                        if (w_rdata[0]) begin
                            n_head_valid = 1'b0;
                        end else begin
                            n_head = w_rdata[LW-1:1];
                        end
                    end
                end
                flpa_pkg::REQ_FREE: begin
                    if (w_free_ok) begin
                        n_head       = AW'(r_free);
                        n_head_valid = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.walk) begin
            n_cur  = r_cur + AW'(1);
            n_left = r_left - PW'(1);
            if (w_last) begin
                n_tail       = r_cur;
                n_tail_valid = 1'b1;
                n_done       = 1'b1;
                n_status     = flpa_pkg::ST_OK;
                n_alloc      = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_head_valid <= 1'b0;
            r_tail       <= '0;
            r_tail_valid <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_head       <= n_head;
            r_head_valid <= n_head_valid;
            r_tail       <= n_tail;
            r_tail_valid <= n_tail_valid;
            r_done       <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_left   <= n_left;
        r_status <= n_status;
        r_alloc  <= n_alloc;
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_alloc_frame = r_alloc;

endmodule

`default_nettype wire

### hw/rtl/free_list_page_allocator.sv
// Free list page allocator: one singly linked list of free page frames,
// one next-frame link and end bit per frame in a link memory.
// Request channel: drive i_req_type and its fields with i_start high; the
// request is taken at a rising edge where i_start is high and o_busy low.
// Kinds: load region (appends each page in ascending order after the last
// loaded page), allocate (pops the head frame) and free (pushes on the head).
// Result channel: o_done is high for exactly one cycle with o_status and
// o_alloc_frame; the receiver cannot stall it, so it must take it then.
// Alloc, free, ignored loads and unknown kinds show their result once the
// execute state ends, and o_busy drops in that same cycle; a new request
// can be taken while the result shows. An alloc reads the head's link at
// the acceptance edge and updates the head as the execute state ends.
// A usable, in-range, non-empty load walks one page per cycle through the
// single link memory write port, and takes no new request until it ends.
// Reset (synchronous, active low) empties the list and forgets the tail;
// the link memory is not cleared and needs no clearing pass, so requests
// can be accepted as soon as reset is released.
`default_nettype none

module free_list_page_allocator #(
    parameter int NUM_PAGES = 65536
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    output logic                                  o_busy,
    input  wire logic [flpa_pkg::REQ_W-1:0]       i_req_type,
    input  wire logic [flpa_pkg::FRAME_W-1:0]     i_region_base_frame,
    input  wire logic [flpa_pkg::PAGES_W-1:0]     i_region_pages,
    input  wire logic                             i_region_usable,
    input  wire logic [flpa_pkg::FRAME_W-1:0]     i_free_frame,
    output logic                                  o_done,
    output logic      [flpa_pkg::STATUS_W-1:0]    o_status,
    output logic      [flpa_pkg::FRAME_W-1:0]     o_alloc_frame
);

    flpa_pkg::t_dp_cmd w_cmd;
    flpa_pkg::t_dp_sts w_sts;

    // request sequencing
    flpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    // list pointers, link memory and results
    flpa_dp #(
        .NUM_PAGES (NUM_PAGES)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_req_type          (i_req_type),
        .i_region_base_frame (i_region_base_frame),
        .i_region_pages      (i_region_pages),
        .i_region_usable     (i_region_usable),
        .i_free_frame        (i_free_frame),
        .o_done              (o_done),
        .o_status            (o_status),
        .o_alloc_frame       (o_alloc_frame)
    );

endmodule

`default_nettype wire

### hw/rtl/flpa_checker.sv
`default_nettype none

`include "free_list_page_allocator_assert.svh"

module flpa_props (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic                             i_busy,
    input  wire logic [flpa_pkg::REQ_W-1:0]       i_req_type,
    input  wire logic                             i_done,
    input  wire logic [flpa_pkg::STATUS_W-1:0]    i_status,
    input  wire logic [flpa_pkg::FRAME_W-1:0]     i_alloc_frame
);

    logic w_accept;
    logic w_accept_alloc;

    // request transaction taken at this edge
    assign w_accept       = i_start && !i_busy;
    assign w_accept_alloc = w_accept && (i_req_type == flpa_pkg::REQ_ALLOC);

    // a result only shows once the block is free again
    `FLPA_ASSERT_IMP(a_done_not_busy, i_done, !i_busy, "result shown while busy")

    // an accepted transaction keeps the block busy in the next cycle
    `FLPA_ASSERT_NXT(a_accept_busy, w_accept, i_busy, "not busy after accept")

    // an accepted alloc answers once its execute state is over
    `FLPA_ASSERT_IMP(a_alloc_latency, w_accept_alloc, ##2 i_done, "alloc result late")

    // a failed request hands out no frame
    `FLPA_ASSERT_IMP(a_frame_zero, i_done && (i_status != flpa_pkg::ST_OK), i_alloc_frame == '0, "frame on failed request")

    // reset leaves the block idle with no result
    `FLPA_ASSERT_IMP(a_reset_quiet, $past(!i_rst_n), !i_done && !i_busy, "activity after reset")

endmodule

bind free_list_page_allocator flpa_props u_flpa_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .i_busy        (o_busy),
    .i_req_type    (i_req_type),
    .i_done        (o_done),
    .i_status      (o_status),
    .i_alloc_frame (o_alloc_frame)
);

`default_nettype wire
